@@ src/tts_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tts_pkg
// shared widths, constants and stage payload types of the frame converter
// ----------------------------------------------------------------------------
package tts_pkg;

  localparam int TIME_W = 52;
  localparam int FRAME_W = 36;
  localparam int TPQ_W = 15;
  localparam int RATE_W = 19;
  localparam int CFG_W = 19;
  localparam int MICRO_W = 20;
  localparam int DIV_W = TPQ_W + MICRO_W;
  localparam int QUOT_W = 33;
  localparam int PROD_W = QUOT_W + RATE_W;
  localparam int RATE_BITS_DEFAULT = 19;

  localparam logic [MICRO_W-1:0] MICROS_PER_SECOND = 20'd1000000;
  localparam logic [TPQ_W-1:0] TPQ_RESET = 15'd480;
  localparam logic [RATE_W-1:0] RATE_RESET = 19'd48000;

  typedef enum logic [0:0] {
    REG_TPQ = 1'b0,
    REG_RATE = 1'b1
  } cfg_idx_t;

  // payload of the whole-second division stages
  typedef struct packed {
    logic [TIME_W-1:0] rem;
    logic [QUOT_W-1:0] quot;
    logic [DIV_W-1:0] div;
    logic [RATE_W-1:0] rate;
  } quot_t;

  // payload of the fractional multiply-divide stages
  typedef struct packed {
    logic [DIV_W-1:0] r;
    logic [DIV_W-1:0] frac;
    logic [DIV_W-1:0] div;
    logic [QUOT_W-1:0] whole;
    logic [RATE_W-1:0] rate;
  } frac_t;

endpackage
`default_nettype wire

@@ src/tts_time_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tts_time_if
// valid/ready channel carrying one score time per transaction
// ----------------------------------------------------------------------------
interface tts_time_if import tts_pkg::*;;
  logic valid;
  logic ready;
  logic [TIME_W-1:0] score_time;
  modport source (output valid, output score_time, input ready);
  modport sink (input valid, input score_time, output ready);
endinterface
`default_nettype wire

@@ src/tts_frame_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tts_frame_if
// valid/ready channel carrying one sample frame index per transaction
// ----------------------------------------------------------------------------
interface tts_frame_if import tts_pkg::*;;
  logic valid;
  logic ready;
  logic [FRAME_W-1:0] frame_index;
  modport source (output valid, output frame_index, input ready);
  modport sink (input valid, input frame_index, output ready);
endinterface
`default_nettype wire

@@ src/time_to_sample_frame_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// time_to_sample_frame_core
// score time to nearest audio sample frame, fully pipelined
// ----------------------------------------------------------------------------
// Converts a score time in tick-microseconds to the nearest sample frame,
// rounding half up. One transaction is accepted every cycle unless the
// output is stalled. One stage forms the divisor, 33 restoring stages
// produce the whole-second quotient one bit each, RATE_BITS stages run the
// fractional multiply-divide one rate bit each, one stage multiplies the
// whole seconds by the rate, and the output register adds the rounded
// fraction. The whole pipeline holds when the output is stalled, so
// nothing is dropped or repeated. A tick resolution of zero acts as one.
module time_to_sample_frame_core import tts_pkg::*; #(
  parameter int RATE_BITS = RATE_BITS_DEFAULT
) (
  input  wire logic             clk,
  input  wire logic             rst,
  tts_time_if.sink              events,
  tts_frame_if.source           frames,
  input  wire logic             cfg_write,
  input  wire logic [0:0]       cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data
);

  // configuration registers
  logic [TPQ_W-1:0]  tpq;
  logic [RATE_W-1:0] rate;

  always_ff @(posedge clk) begin
    if (rst) begin
      tpq <= TPQ_RESET;
      rate <= RATE_RESET;
    end else if (cfg_write) begin
      case (cfg_idx_t'(cfg_index))
        REG_TPQ: tpq <= cfg_data[TPQ_W-1:0];
        REG_RATE: rate <= cfg_data[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // single shared advance: the pipe moves unless the output is stalled
  logic en;
  logic out_valid;
  assign en = !out_valid || frames.ready;
  assign events.ready = en;

  // entry stage: divisor is ticks per quarter times one million
  logic [TPQ_W-1:0] tpq_eff;
  logic             s0_valid;
  quot_t            s0_data;

  assign tpq_eff = (tpq == '0) ? TPQ_W'(1) : tpq;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= events.valid;
    end
    if (en) begin
      s0_data.rem <= events.score_time;
      s0_data.quot <= '0;
      s0_data.div <= DIV_W'(tpq_eff) * DIV_W'(MICROS_PER_SECOND);
      s0_data.rate <= rate;
    end
  end

  // whole-second division, most significant quotient bit first
  logic  qv [0:QUOT_W];
  quot_t qd [0:QUOT_W];

  assign qv[0] = s0_valid;
  assign qd[0] = s0_data;

  for (genvar j = 0; j < QUOT_W; j++) begin : g_quot
    tts_quot_stage #(
      .SHIFT(QUOT_W - 1 - j)
    ) u_stage (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (qv[j]),
      .in_data  (qd[j]),
      .out_valid(qv[j+1]),
      .out_data (qd[j+1])
    );
  end

  // fractional multiply-divide, remainder of the division is the fraction
  logic                 fv [0:RATE_BITS];
  frac_t                fd [0:RATE_BITS];
  logic [RATE_BITS-1:0] fq [0:RATE_BITS];

  assign fv[0] = qv[QUOT_W];
  assign fd[0].r = '0;
  assign fd[0].frac = qd[QUOT_W].rem[DIV_W-1:0];
  assign fd[0].div = qd[QUOT_W].div;
  assign fd[0].whole = qd[QUOT_W].quot;
  assign fd[0].rate = qd[QUOT_W].rate;
  assign fq[0] = '0;

  for (genvar k = 0; k < RATE_BITS; k++) begin : g_frac
    tts_frac_stage #(
      .BIT_POS(RATE_BITS - 1 - k),
      .Q_W    (RATE_BITS)
    ) u_stage (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (fv[k]),
      .in_data  (fd[k]),
      .in_q     (fq[k]),
      .out_valid(fv[k+1]),
      .out_data (fd[k+1]),
      .out_q    (fq[k+1])
    );
  end

  // whole seconds times rate, rounding flag from the final remainder
  logic                 m_valid;
  logic [PROD_W-1:0]    m_prod;
  logic [RATE_BITS-1:0] m_q;
  logic                 m_rnd;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (en) begin
      m_valid <= fv[RATE_BITS];
    end
    if (en) begin
      m_prod <= fd[RATE_BITS].whole * fd[RATE_BITS].rate;
      m_q <= fq[RATE_BITS];
      // half the divisor or more rounds up
      m_rnd <= ((DIV_W+1)'(fd[RATE_BITS].r) << 1) >= (DIV_W+1)'(fd[RATE_BITS].div);
    end
  end

  // output register, result wraps to the frame width
  logic [FRAME_W-1:0] frame;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= m_valid;
    end
    if (en) begin
      frame <= m_prod[FRAME_W-1:0] + FRAME_W'(m_q) + FRAME_W'(m_rnd);
    end
  end

  assign frames.valid = out_valid;
  assign frames.frame_index = frame;

endmodule
`default_nettype wire

@@ src/tts_quot_stage.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tts_quot_stage
// one restoring division step: settles one whole-second quotient bit
// ----------------------------------------------------------------------------
module tts_quot_stage import tts_pkg::*; #(
  parameter int SHIFT = 0
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  en,
  input  wire logic  in_valid,
  input  wire quot_t in_data,
  output logic       out_valid,
  output quot_t      out_data
);

  localparam int CMP_W = DIV_W + QUOT_W;

  logic [CMP_W-1:0] dsh;
  logic [CMP_W-1:0] remx;
  logic             take;
  quot_t            data_next;

  always_comb begin
    dsh = CMP_W'(in_data.div) << SHIFT;
    remx = CMP_W'(in_data.rem);
    take = remx >= dsh;
    data_next = in_data;
    if (take) begin
      data_next.rem = TIME_W'(remx - dsh);
      data_next.quot[SHIFT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_data <= data_next;
    end
  end

endmodule
`default_nettype wire

@@ src/tts_frac_stage.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tts_frac_stage
// one multiply-divide step on the fractional second, one rate bit per stage
// ----------------------------------------------------------------------------
module tts_frac_stage import tts_pkg::*; #(
  parameter int BIT_POS = 0,
  parameter int Q_W = RATE_BITS_DEFAULT
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           en,
  input  wire logic           in_valid,
  input  wire frac_t          in_data,
  input  wire logic [Q_W-1:0] in_q,
  output logic                out_valid,
  output frac_t               out_data,
  output logic [Q_W-1:0]      out_q
);

  localparam int R_W = DIV_W + 2;

  logic             rbit;
  logic [R_W-1:0]   rn;
  logic [R_W-1:0]   d1;
  logic [R_W-1:0]   d2;
  logic [1:0]       qd;
  logic [Q_W:0]     qs;
  frac_t            data_next;

  // bits of the rate above its field width read as zero
  if (BIT_POS < RATE_W) begin : g_bit
    assign rbit = in_data.rate[BIT_POS];
  end else begin : g_nobit
    assign rbit = 1'b0;
  end

  always_comb begin
    d1 = R_W'(in_data.div);
    d2 = R_W'(in_data.div) << 1;
    rn = (R_W'(in_data.r) << 1) + (rbit ? R_W'(in_data.frac) : R_W'(0));
    data_next = in_data;
    // partial remainder stays below three divisors
    if (rn >= d2) begin
      qd = 2'd2;
      data_next.r = DIV_W'(rn - d2);
    end else if (rn >= d1) begin
      qd = 2'd1;
      data_next.r = DIV_W'(rn - d1);
    end else begin
      qd = 2'd0;
      data_next.r = DIV_W'(rn);
    end
    qs = {in_q, 1'b0} + (Q_W+1)'(qd);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_data <= data_next;
      out_q <= qs[Q_W-1:0];
    end
  end

endmodule
`default_nettype wire
